// ===== rtl/mbp_pkg.sv =====
// shared types and constants for the msb-first bit packer
`timescale 1ns / 1ps
`default_nettype none
package mbp_pkg;

	// operation codes of an input request
	typedef enum logic [0:0] {
		OP_PUT   = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	localparam int NBITS_W = 5;   // width of the nbits field
	localparam int CODE_W  = 16;  // width of the code field
	localparam int BYTE_W  = 8;   // packed output byte
	localparam int RES_W   = 7;   // residual bits held between requests
	localparam int RCNT_W  = 3;   // residual bit count
	localparam int LEN_W   = 5;   // pending bit count of one job, up to 31
	localparam int CNT_W   = 2;   // bytes in one job, up to 3

	// queue fill status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/msb_first_bit_packer.sv =====
// top level of the msb-first variable-length bit packer
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+---------------------
//  in      | input     | op, nbits, code_value| in_valid / in_ready
//  out     | output    | out_byte, last       | out_valid / out_ready
//
// the front takes one request per cycle while the two-entry job queue has room
// the back emits one byte per cycle unless out_ready holds it; the most bytes one request gives
// come from a put of MAX_CODE_BITS bits onto 7 residual bits: (7+MAX_CODE_BITS)/8 bytes
// a put that completes no byte and a flush of an empty residual push no job to the queue
// reset clears the residual, the queue pointers and fill count, and the output valid flag
// out_ready low holds the output byte; the queue then fills and in_ready drops
`timescale 1ns / 1ps
`default_nettype none
module msb_first_bit_packer #(
	parameter int MAX_CODE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         op,
	input  wire logic [mbp_pkg::NBITS_W-1:0]  nbits,
	input  wire logic [mbp_pkg::CODE_W-1:0]   code_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [mbp_pkg::BYTE_W-1:0]        out_byte,
	output logic                              last
);
	// accumulator holds the residual plus one saturated code
	localparam int ACC_W  = MAX_CODE_BITS + mbp_pkg::RES_W;
	localparam int JOB_W  = ACC_W + mbp_pkg::LEN_W + mbp_pkg::CNT_W;

	mbp_pkg::q_stat_t            q_stat;
	logic                        push;
	logic                        pop;
	logic [ACC_W-1:0]            f_acc;
	logic [mbp_pkg::LEN_W-1:0]   f_len;
	logic [mbp_pkg::CNT_W-1:0]   f_nbytes;
	logic [JOB_W-1:0]            q_out;

	// front: residual register and job building
	mbp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.ACC_W(ACC_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.nbits      (nbits),
		.code_value (code_value),
		.q_stat     (q_stat),
		.push       (push),
		.job_acc    (f_acc),
		.job_len    (f_len),
		.job_nbytes (f_nbytes)
	);

	// jobs waiting for the back end
	mbp_queue #(
		.DATA_W(JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_acc, f_len, f_nbytes}),
		.pop       (pop),
		.pop_data  (q_out),
		.q_stat    (q_stat)
	);

	// back: byte extraction and output register
	mbp_back #(
		.ACC_W(ACC_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.job_acc    (q_out[JOB_W-1 -: ACC_W]),
		.job_len    (q_out[mbp_pkg::CNT_W +: mbp_pkg::LEN_W]),
		.job_nbytes (q_out[mbp_pkg::CNT_W-1:0]),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== rtl/mbp_front.sv =====
// front end: residual state, code masking and job building
`timescale 1ns / 1ps
`default_nettype none
module mbp_front #(
	parameter int MAX_CODE_BITS = 16,
	parameter int ACC_W = MAX_CODE_BITS + mbp_pkg::RES_W
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         op,
	input  wire logic [mbp_pkg::NBITS_W-1:0]  nbits,
	input  wire logic [mbp_pkg::CODE_W-1:0]   code_value,
	input  wire mbp_pkg::q_stat_t             q_stat,
	output logic                              push,
	output logic [ACC_W-1:0]                  job_acc,
	output logic [mbp_pkg::LEN_W-1:0]         job_len,
	output logic [mbp_pkg::CNT_W-1:0]         job_nbytes
);
	localparam int WIDE_W = (ACC_W > mbp_pkg::CODE_W) ? ACC_W : mbp_pkg::CODE_W;

	logic [mbp_pkg::RES_W-1:0]  res_bits_q;
	logic [mbp_pkg::RCNT_W-1:0] res_cnt_q;

	logic                          accept;
	logic                          is_flush;
	logic [mbp_pkg::LEN_W-1:0]     n_sat;
	logic [WIDE_W-1:0]             code_m;
	logic [WIDE_W-1:0]             acc_w;
	logic [ACC_W-1:0]              acc;
	logic [mbp_pkg::LEN_W-1:0]     len;
	logic [mbp_pkg::RES_W-1:0]     res_next;
	logic [mbp_pkg::BYTE_W-1:0]    flush_byte;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign is_flush = (op == mbp_pkg::OP_FLUSH);

	always_comb begin
		// saturate the code length
		if (mbp_pkg::LEN_W'(nbits) > mbp_pkg::LEN_W'(MAX_CODE_BITS)) begin
			n_sat = mbp_pkg::LEN_W'(MAX_CODE_BITS);
		end else begin
			n_sat = mbp_pkg::LEN_W'(nbits);
		end
		code_m   = WIDE_W'(code_value) & ~({WIDE_W{1'b1}} << n_sat);
		acc_w    = (WIDE_W'(res_bits_q) << n_sat) | code_m;
		acc      = acc_w[ACC_W-1:0];
		len      = mbp_pkg::LEN_W'(res_cnt_q) + n_sat;
		res_next = acc[mbp_pkg::RES_W-1:0] & ~({mbp_pkg::RES_W{1'b1}} << len[2:0]);
		// residual left-aligned, zero-padded
		flush_byte = mbp_pkg::BYTE_W'({1'b0, res_bits_q}
			<< (mbp_pkg::LEN_W'(mbp_pkg::BYTE_W) - mbp_pkg::LEN_W'(res_cnt_q)));

		if (is_flush) begin
			push       = accept && (res_cnt_q != '0);
			job_acc    = ACC_W'(flush_byte);
			job_len    = mbp_pkg::LEN_W'(mbp_pkg::BYTE_W);
			job_nbytes = mbp_pkg::CNT_W'(1);
		end else begin
			push       = accept && (len[mbp_pkg::LEN_W-1:3] != '0);
			job_acc    = acc;
			job_len    = len;
			job_nbytes = len[mbp_pkg::LEN_W-1:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bits_q <= '0;
			res_cnt_q  <= '0;
		end else if (accept) begin
			if (is_flush) begin
				res_bits_q <= '0;
				res_cnt_q  <= '0;
			end else begin
				res_bits_q <= res_next;
				res_cnt_q  <= len[2:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mbp_queue.sv =====
// two-entry job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module mbp_queue #(
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output mbp_pkg::q_stat_t       q_stat
);
	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;

	assign pop_data     = entry_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == 2'd2);
	assign q_stat.empty = (fill_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mbp_back.sv =====
// back end: emits a job's bytes one per cycle, unless stalled, to the output register
`timescale 1ns / 1ps
`default_nettype none
module mbp_back #(
	parameter int ACC_W = 23
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mbp_pkg::q_stat_t             q_stat,
	input  wire logic [ACC_W-1:0]             job_acc,
	input  wire logic [mbp_pkg::LEN_W-1:0]    job_len,
	input  wire logic [mbp_pkg::CNT_W-1:0]    job_nbytes,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [mbp_pkg::BYTE_W-1:0]        out_byte,
	output logic                              last
);
	logic [mbp_pkg::CNT_W-1:0]  idx_q;
	logic                       out_valid_q;
	logic [mbp_pkg::BYTE_W-1:0] out_byte_q;
	logic                       last_q;

	logic                       load;
	logic                       final_byte;
	logic [mbp_pkg::LEN_W-1:0]  sh;
	logic [mbp_pkg::BYTE_W-1:0] cur_byte;

	always_comb begin
		load       = !q_stat.empty && (!out_valid_q || out_ready);
		final_byte = (idx_q == job_nbytes - mbp_pkg::CNT_W'(1));
		pop        = load && final_byte;
		sh         = job_len - mbp_pkg::LEN_W'({mbp_pkg::CNT_W'(idx_q + mbp_pkg::CNT_W'(1)),
			3'b000});
		cur_byte   = mbp_pkg::BYTE_W'(job_acc >> sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? '0 : idx_q + mbp_pkg::CNT_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			last_q     <= final_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== rtl/mbp_checker.sv =====
// port-level checker for the bit packer and its bind
`timescale 1ns / 1ps
`default_nettype none
module mbp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [mbp_pkg::BYTE_W-1:0]   out_byte,
	input wire logic                         last
);
	// a stalled output byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output byte changed while stalled");

	// the next byte of the same request follows without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a multi-byte request");

	// input side only backs up after it took a request
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready fell with no accepted request");

	// nothing is offered right out of reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (.*);
`default_nettype wire
